@@ rtl/brfb_pkg.sv @@
// Package for the brake request frame builder.
// Holds payload structs, controller states and frame constants; no dependencies.
package brfb_pkg;

  localparam int TTC_W   = 16;
  localparam int DEM_W   = 24;
  localparam int CNT_W   = 4;
  localparam int NUM_W   = 35;  // widest numerator: (T - ttc) * 7 * 65536
  localparam int DEN_W   = 20;  // widest divisor: 10 * T
  localparam int QLIM_W  = 19;  // demand magnitude bits
  localparam int STEP_W  = 6;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(NUM_W - 1);

  localparam logic [TTC_W-1:0]   WARN_RESET    = 16'd384;
  localparam logic [DEM_W:0]     DEMAND_OFFSET = 25'd1028063;
  localparam logic [7:0]         MODE_EXT      = 8'hD0;
  localparam logic [7:0]         MODE_NORM     = 8'hCC;
  localparam logic [7:0]         FILL_BYTE     = 8'hFF;
  localparam logic [7:0]         CHK_SALT      = 8'h2A + 8'h0B + 8'h04 + 8'h0C;
  localparam logic [15:0]        CODE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [TTC_W-1:0] time_to_collision;
    logic             brake_request;
  } in_item_t;

  typedef struct packed {
    logic [63:0]      frame;
    logic [15:0]      accel_code;
    logic [CNT_W-1:0] sequence_count;
    logic [3:0]       check_nibble;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // latch operands, bump counter
    logic step;      // one restoring division step
    logic update;    // fold quotient into demand
    logic load_out;  // pack frame into output register
  } dp_cmd_t;

endpackage

@@ rtl/brfb_ctrl.sv @@
// Controller for the brake request frame builder.
// Sequences load, divide, update and emit; uses brfb_pkg.
module brfb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output brfb_pkg::dp_cmd_t cmd
);

  brfb_pkg::state_t            state_r, state_nxt;
  logic [brfb_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brfb_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      brfb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = brfb_pkg::ST_DIVIDE;
        end
      end
      brfb_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (step_r == brfb_pkg::DIV_LAST) begin
          state_nxt = brfb_pkg::ST_UPDATE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      brfb_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = brfb_pkg::ST_EMIT;
      end
      brfb_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = brfb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brfb_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/brfb_datapath.sv @@
// Datapath for the brake request frame builder: warning time register,
// demand and counter state, serial divider and frame packer. Uses brfb_pkg.
module brfb_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [brfb_pkg::TTC_W-1:0]      cfg_data,
  input  brfb_pkg::in_item_t              in_data,
  input  brfb_pkg::dp_cmd_t               cmd,
  output brfb_pkg::out_item_t             out_data
);

  localparam int NW = brfb_pkg::NUM_W;
  localparam int DW = brfb_pkg::DEN_W;
  localparam int MW = brfb_pkg::DEM_W;
  localparam int QW = brfb_pkg::QLIM_W;
  localparam int TW = brfb_pkg::TTC_W;
  localparam int CW = brfb_pkg::CNT_W;

  logic [TW-1:0]       warn_r;
  logic signed [MW-1:0] demand_r, demand_nxt;
  logic [CW-1:0]       count_r;
  logic [7:0]          mode_r;
  logic                below_r;
  logic [NW-1:0]       rq_r, rq_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]       den_r;
  brfb_pkg::out_item_t out_r, out_nxt;

  // operand setup
  logic [TW-1:0]   t_eff;
  logic            ge;
  logic [TW-1:0]   diff;
  logic [QW-1:0]   prod7;
  logic [NW-1:0]   num;
  logic [DW-1:0]   den;

  always_comb begin
    t_eff = (warn_r == '0) ? TW'(1) : warn_r;
    ge    = in_data.time_to_collision >= t_eff;
    diff  = ge ? (in_data.time_to_collision - t_eff) : (t_eff - in_data.time_to_collision);
    prod7 = ({3'b000, diff} << 3) - {3'b000, diff};
    if (ge) begin
      num = {3'b000, diff, 16'h0000};
      den = ({4'h0, t_eff} << 3) + ({4'h0, t_eff} << 1);
    end else begin
      num = {prod7, 16'h0000};
      den = {4'h0, t_eff};
    end
  end

  // restoring division step
  logic [DW:0] trial;
  logic [DW:0] trial_diff;
  logic        qbit;

  always_comb begin
    trial      = {rem_r, rq_r[NW-1]};
    trial_diff = trial - {1'b0, den_r};
    qbit       = trial >= {1'b0, den_r};
    rem_nxt    = qbit ? trial_diff[DW-1:0] : trial[DW-1:0];
    rq_nxt     = {rq_r[NW-2:0], qbit};
  end

  // demand update
  logic signed [MW-1:0] dsum;

  always_comb begin
    dsum       = demand_r + $signed({{(MW-QW){1'b0}}, rq_r[QW-1:0]});
    demand_nxt = demand_r;
    if (below_r) begin
      demand_nxt = -$signed({{(MW-QW){1'b0}}, rq_r[QW-1:0]});
    end else if (|rq_r[NW-1:QW]) begin
      demand_nxt = '0;
    end else if (!dsum[MW-1] && (dsum != '0)) begin
      demand_nxt = '0;
    end else begin
      demand_nxt = dsum;
    end
  end

  // code and frame packing
  logic [MW:0]   acc;
  logic [MW-5:0] acc_sh;
  logic [15:0]   code;
  logic [7:0]    csum;
  logic [3:0]    chk;

  always_comb begin
    acc    = {demand_r[MW-1], demand_r} + brfb_pkg::DEMAND_OFFSET;
    acc_sh = acc[MW:5];
    if (acc[MW]) begin
      code = '0;
    end else if (|acc_sh[MW-5:16]) begin
      code = brfb_pkg::CODE_MAX;
    end else begin
      code = acc_sh[15:0];
    end
    csum = code[7:0] + code[15:8] + mode_r
         + brfb_pkg::FILL_BYTE + brfb_pkg::FILL_BYTE
         + brfb_pkg::FILL_BYTE + brfb_pkg::FILL_BYTE
         + {4'h0, count_r} + brfb_pkg::CHK_SALT;
    chk  = csum[7:4] + csum[3:0];
    out_nxt.frame = {chk, count_r,
                     brfb_pkg::FILL_BYTE, brfb_pkg::FILL_BYTE,
                     brfb_pkg::FILL_BYTE, brfb_pkg::FILL_BYTE,
                     mode_r, code[15:8], code[7:0]};
    out_nxt.accel_code     = code;
    out_nxt.sequence_count = count_r;
    out_nxt.check_nibble   = chk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_r   <= brfb_pkg::WARN_RESET;
      demand_r <= '0;
      count_r  <= '0;
    end else begin
      if (cfg_we) begin
        warn_r <= cfg_data;
      end
      if (cmd.load) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.update) begin
        demand_r <= demand_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_r    <= num;
      den_r   <= den;
      rem_r   <= '0;
      below_r <= !ge;
      mode_r  <= in_data.brake_request ? brfb_pkg::MODE_EXT : brfb_pkg::MODE_NORM;
    end else if (cmd.step) begin
      rq_r  <= rq_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/brake_request_frame_builder.sv @@
// Top level of the brake request frame builder.
// Joins brfb_ctrl and brfb_datapath; uses brfb_pkg.
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one time-to-collision
//   sample item with a brake request flag. Output channel
//   (out_valid/out_ready/out_data) returns one 8-byte frame item per input,
//   with the demand code, rolling counter and checksum nibble alongside.
//   cfg_we/cfg_data write the warning time; write only while idle.
// Timing:
//   out_valid rises once 35 restoring division steps (one quotient bit
//   per cycle, sized by the 35-bit numerator), one demand update and one
//   pack step have run after the accepting edge; operands load on that edge.
//   in_ready is high only between items, so one item is in flight and a new
//   one is taken only once the last has been packed, even while that
//   frame still sits in the output register.
// Reset: synchronous, active low. Demand and counter clear, warning time
//   returns to 1.5 s (384 in Q8.8), out_valid clears.
// Stall: a finished frame waits in the output register while out_ready is
//   low; a following item finishes its division, then waits in the pack
//   state until the register frees up. Nothing is dropped.
module brake_request_frame_builder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [brfb_pkg::TTC_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  brfb_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output brfb_pkg::out_item_t        out_data
);

  brfb_pkg::dp_cmd_t cmd;

  // sequencer: owns the handshakes and the step counter
  brfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // state, divider and packer
  brfb_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .out_data (out_data)
  );

endmodule

@@ sim/brake_frame_checker.sv @@
// Checker for the brake request frame builder: follows the warning-time writes,
// predicts every frame item and compares it with what the block sends out.
// Depends on brfb_pkg for the payload structs.
module brake_frame_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  brfb_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  brfb_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] EXT_BRAKE_MODE = 8'hD0;
  localparam logic [7:0] NORM_MODE      = 8'hCC;
  localparam logic [7:0] FILLER_BYTE    = 8'hFF;
  localparam logic [7:0] CHECK_SALT     = 8'h2A + 8'h0B + 8'h04 + 8'h0C;

  logic [15:0]         warn_time;
  longint              demand_q16;     // 1/65536 m/s2
  logic [3:0]          rolling_count;
  brfb_pkg::out_item_t frames_due[$];
  brfb_pkg::out_item_t oldest_frame;

  function automatic brfb_pkg::out_item_t build_brake_frame(input brfb_pkg::in_item_t s);
    longint              t;
    longint              ttc;
    longint              shifted;
    logic [15:0]         code;
    logic [7:0]          mode;
    logic [7:0]          sum;
    logic [7:0]          folded;
    brfb_pkg::out_item_t r;
    t   = (warn_time == 16'd0) ? 64'sd1 : longint'(warn_time);
    ttc = longint'(s.time_to_collision);
    rolling_count = rolling_count + 4'd1;
    if (ttc >= t) begin
      demand_q16 = demand_q16 + ((ttc - t) * 65536) / (t * 10);
      if (demand_q16 > 0) demand_q16 = 0;
    end else begin
      demand_q16 = -(((t - ttc) * 458752) / t);
    end
    shifted = demand_q16 + 1028063;
    if (shifted < 0) shifted = 0;
    shifted = shifted / 32;
    if (shifted > 65535) shifted = 65535;
    code = shifted[15:0];
    mode = s.brake_request ? EXT_BRAKE_MODE : NORM_MODE;
    sum = code[7:0] + code[15:8] + mode + FILLER_BYTE + FILLER_BYTE + FILLER_BYTE
        + FILLER_BYTE + {4'h0, rolling_count} + CHECK_SALT;
    folded = sum + {4'h0, sum[7:4]};
    r.frame = {folded[3:0], rolling_count, {4{FILLER_BYTE}}, mode, code};
    r.accel_code     = code;
    r.sequence_count = rolling_count;
    r.check_nibble   = folded[3:0];
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      warn_time     = 16'd384;
      demand_q16    = 0;
      rolling_count = 4'd0;
      frames_due.delete();
    end else begin
      if (cfg_we) warn_time = cfg_data;
      if (in_valid && in_ready) frames_due.push_back(build_brake_frame(in_data));
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("frame: result item 0x%0h with nothing expected", out_data.frame);
          fail_count++;
        end else begin
          oldest_frame = frames_due.pop_front();
          compare_field("frame", oldest_frame.frame, out_data.frame);
          compare_field("accel_code", 64'(oldest_frame.accel_code),
                        64'(out_data.accel_code));
          compare_field("sequence_count", 64'(oldest_frame.sequence_count),
                        64'(out_data.sequence_count));
          compare_field("check_nibble", 64'(oldest_frame.check_nibble),
                        64'(out_data.check_nibble));
        end
      end
    end
    pending_frames = frames_due.size();
  end

endmodule

@@ sim/brake_request_frame_builder_tb.sv @@
// Testbench top for the brake request frame builder: drives samples and
// warning-time writes, with random gaps and stalls, and gives the verdict.
// Depends on brfb_pkg, brake_request_frame_builder and brake_frame_checker.
module brake_request_frame_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake at all before the run is declared hung. One item
  // needs its division, update and pack plus random gaps and stalls, so this is
  // many times the slowest legal stretch.
  localparam int HANG_LIMIT   = 4000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES   = 8;
  localparam int SETTLE_CYCLES = 48;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  brfb_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  brfb_pkg::out_item_t out_data;
  int                  fail_count;
  int                  pending_frames;
  int                  quiet_cycles;
  bit                  sender_idle;
  bit                  receiver_stall;

  // Directed samples, run at the reset warning time of 1.5 s (384):
  // ttc extremes, exactly at / just around the threshold, both mode bytes,
  // and climbs back from full braking so the demand crosses up to zero.
  localparam logic [16:0] DIRECTED_SAMPLES [20] = '{
    {16'd0, 1'b1}, {16'd65535, 1'b0}, {16'd384, 1'b1}, {16'd383, 1'b0},
    {16'd385, 1'b1}, {16'd0, 1'b0}, {16'd400, 1'b1}, {16'd500, 1'b0},
    {16'd768, 1'b1}, {16'd1000, 1'b0}, {16'd2000, 1'b1}, {16'd192, 1'b0},
    {16'd65535, 1'b1}, {16'd1, 1'b0}, {16'd384, 1'b0}, {16'd383, 1'b1},
    {16'd65534, 1'b0}, {16'd0, 1'b1}, {16'd3840, 1'b0}, {16'd32768, 1'b1}
  };

  brake_request_frame_builder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  brake_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending_frames (pending_frames)
  );

  // 2 ns clock, rising edges on odd ns
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hang detection: any handshake or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts of random length while stalls are enabled.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_stall && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item. Returns right after the accepting rising edge, so valid
  // stays high into the next call when items go back to back.
  task automatic send_sample(input brfb_pkg::in_item_t ttc_item);
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ttc_item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Block until every predicted frame has come back.
  task automatic drain_results();
    while (pending_frames != 0) @(negedge clk);
  endtask

  // Register writes only with the block idle: sender off, all frames out.
  task automatic set_warning_time(input logic [15:0] warn);
    sender_quiet();
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= warn;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // ttc values biased toward the threshold and toward slow recoveries, where
  // the demand builds back up over many items, plus the full range.
  function automatic logic [15:0] pick_ttc(input logic [15:0] warn);
    int base;
    int v;
    base = (warn == 16'd0) ? 1 : int'(warn);
    case ($urandom_range(0, 9)) inside
      0: v = 0;
      1: v = 65535;
      2, 3: v = base + int'($urandom_range(0, base / 2 + 1));
      4: v = base - int'($urandom_range(0, base));
      5: v = base - 1 + int'($urandom_range(0, 2));
      6: v = int'($urandom_range(0, 255));
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  initial begin
    brfb_pkg::in_item_t ttc_item;
    logic [15:0]        warn;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = 16'd0;
    in_valid       = 1'b0;
    in_data        = '0;
    sender_idle    = 1'b1;
    receiver_stall = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold.
    foreach (DIRECTED_SAMPLES[i]) begin
      send_sample(brfb_pkg::in_item_t'(DIRECTED_SAMPLES[i]));
    end

    // Random phases, each at its own warning time: the extremes, a written
    // zero (acts as one), small and random values, and the reset value again.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: warn = 16'd1;
        1: warn = 16'hFFFF;
        2: warn = 16'd0;
        3: warn = 16'($urandom_range(1, 65535));
        4: warn = 16'd16;
        5: warn = 16'($urandom_range(64, 4096));
        6: warn = 16'($urandom_range(1, 65535));
        default: warn = 16'd384;
      endcase
      // phase 3 runs without gaps; the last phase too, to close the run clean
      sender_idle    = (phase != 3) && (phase != NUM_PHASES - 1);
      receiver_stall = sender_idle;
      set_warning_time(warn);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // once mid-run: hold the sender until the pipe is empty
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) begin
          sender_quiet();
          drain_results();
        end
        ttc_item.time_to_collision = pick_ttc(warn);
        ttc_item.brake_request     = 1'($urandom_range(0, 1));
        send_sample(ttc_item);
      end
    end

    sender_quiet();
    drain_results();
    // anything arriving now is an extra frame and gets flagged by the checker
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
